// ===== rtl/tcd_pkg.sv =====
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared types and constants for the tilt classifier with debounce.
// ----------------------------------------------------------------------------
`default_nettype none

package tcd_pkg;

  localparam int unsigned SampleW  = 8;
  localparam int unsigned LimitW   = 4;
  localparam int unsigned RunW     = 5;
  localparam int unsigned NumThr   = 5;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;
  localparam int unsigned RegIdxW  = 3;

  typedef enum logic [2:0] {
    CLS_UNKNOWN = 3'd0,
    CLS_BACK    = 3'd1,
    CLS_RIGHT   = 3'd2,
    CLS_LEVEL   = 3'd3,
    CLS_FRONT   = 3'd4,
    CLS_LEFT    = 3'd5
  } tcd_class_e;

  typedef enum logic [1:0] {
    MODE_RAW    = 2'd0,
    MODE_AXIS   = 2'd1,
    MODE_STATUS = 2'd2
  } tcd_mode_e;

  localparam logic [RegIdxW-1:0] REG_OUTPUT_MODE    = 3'd0;
  localparam logic [RegIdxW-1:0] REG_DEBOUNCE_LIMIT = 3'd1;
  localparam logic [RegIdxW-1:0] REG_UNKNOWN_MAX    = 3'd2;
  localparam logic [RegIdxW-1:0] REG_BACK_MAX       = 3'd3;
  localparam logic [RegIdxW-1:0] REG_RIGHT_MAX      = 3'd4;
  localparam logic [RegIdxW-1:0] REG_LEVEL_MAX      = 3'd5;
  localparam logic [RegIdxW-1:0] REG_FRONT_MAX      = 3'd6;

  localparam logic [1:0]         RST_OUTPUT_MODE    = 2'd1;
  localparam logic [LimitW-1:0]  RST_DEBOUNCE_LIMIT = 4'd4;
  localparam logic [SampleW-1:0] RST_UNKNOWN_MAX    = 8'd0;
  localparam logic [SampleW-1:0] RST_BACK_MAX       = 8'd48;
  localparam logic [SampleW-1:0] RST_RIGHT_MAX      = 8'd99;
  localparam logic [SampleW-1:0] RST_LEVEL_MAX      = 8'd153;
  localparam logic [SampleW-1:0] RST_FRONT_MAX      = 8'd204;

  localparam logic [RunW-1:0]    RUN_MAX            = 5'd16;

  typedef struct packed {
    logic [1:0]                      mode;
    logic [LimitW-1:0]               limit;
    logic [NumThr-1:0][SampleW-1:0]  thr;
  } tcd_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/tcd_regs.sv =====
// ----------------------------------------------------------------------------
// tcd_regs
// APB-style configuration registers: output mode, debounce limit, thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_regs import tcd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output tcd_cfg_t              cfg_o
);

  logic [1:0]                     mode_q;
  logic [LimitW-1:0]              limit_q;
  logic [NumThr-1:0][SampleW-1:0] thr_q;
  logic [RegIdxW-1:0]             idx;
  logic                           wr_en;

  assign idx    = paddr[AddrW-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= RST_OUTPUT_MODE;
      limit_q  <= RST_DEBOUNCE_LIMIT;
      thr_q[0] <= RST_UNKNOWN_MAX;
      thr_q[1] <= RST_BACK_MAX;
      thr_q[2] <= RST_RIGHT_MAX;
      thr_q[3] <= RST_LEVEL_MAX;
      thr_q[4] <= RST_FRONT_MAX;
    end else if (wr_en) begin
      unique case (idx)
        REG_OUTPUT_MODE:    mode_q   <= pwdata[1:0];
        REG_DEBOUNCE_LIMIT: limit_q  <= pwdata[LimitW-1:0];
        REG_UNKNOWN_MAX:    thr_q[0] <= pwdata[SampleW-1:0];
        REG_BACK_MAX:       thr_q[1] <= pwdata[SampleW-1:0];
        REG_RIGHT_MAX:      thr_q[2] <= pwdata[SampleW-1:0];
        REG_LEVEL_MAX:      thr_q[3] <= pwdata[SampleW-1:0];
        REG_FRONT_MAX:      thr_q[4] <= pwdata[SampleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_OUTPUT_MODE:    prdata = {{(DataW-2){1'b0}}, mode_q};
      REG_DEBOUNCE_LIMIT: prdata = {{(DataW-LimitW){1'b0}}, limit_q};
      REG_UNKNOWN_MAX:    prdata = {{(DataW-SampleW){1'b0}}, thr_q[0]};
      REG_BACK_MAX:       prdata = {{(DataW-SampleW){1'b0}}, thr_q[1]};
      REG_RIGHT_MAX:      prdata = {{(DataW-SampleW){1'b0}}, thr_q[2]};
      REG_LEVEL_MAX:      prdata = {{(DataW-SampleW){1'b0}}, thr_q[3]};
      REG_FRONT_MAX:      prdata = {{(DataW-SampleW){1'b0}}, thr_q[4]};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o.mode  = mode_q;
  assign cfg_o.limit = limit_q;
  assign cfg_o.thr   = thr_q;

endmodule

`default_nettype wire

// ===== rtl/tcd_classify.sv =====
// ----------------------------------------------------------------------------
// tcd_classify
// Sorts a sample into the first class whose upper threshold it does not exceed.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_classify import tcd_pkg::*; (
  input  wire logic [SampleW-1:0]             sample_i,
  input  wire logic [NumThr-1:0][SampleW-1:0] thr_i,
  output tcd_class_e                          class_o
);

  always_comb begin
    priority if (sample_i <= thr_i[0]) begin
      class_o = CLS_UNKNOWN;
    end else if (sample_i <= thr_i[1]) begin
      class_o = CLS_BACK;
    end else if (sample_i <= thr_i[2]) begin
      class_o = CLS_RIGHT;
    end else if (sample_i <= thr_i[3]) begin
      class_o = CLS_LEVEL;
    end else if (sample_i <= thr_i[4]) begin
      class_o = CLS_FRONT;
    end else begin
      class_o = CLS_LEFT;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tcd_debounce.sv =====
// ----------------------------------------------------------------------------
// tcd_debounce
// Debounce state and mapping of the accepted class to the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_debounce import tcd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [SampleW-1:0] sample_i,
  input  wire tcd_class_e         class_i,
  input  wire tcd_cfg_t           cfg_i,
  output logic      [SampleW-1:0] raw_value_o,
  output logic signed [1:0]       left_right_o,
  output logic signed [1:0]       back_front_o,
  output logic      [2:0]         status_code_o
);

  tcd_class_e            cand_q, cand_d;
  tcd_class_e            acc_q, acc_d;
  logic [RunW-1:0]       run_q, run_d;
  logic [RunW-1:0]       limit_ext;
  logic                  classifying;

  assign limit_ext   = {1'b0, cfg_i.limit};
  assign classifying = (cfg_i.mode == MODE_AXIS) || (cfg_i.mode == MODE_STATUS);

  always_comb begin
    cand_d = cand_q;
    acc_d  = acc_q;
    run_d  = run_q;
    if (classifying) begin
      priority if (class_i != cand_q) begin
        cand_d = class_i;
        run_d  = '0;
      end else if (run_q < limit_ext) begin
        run_d = run_q + 1'b1;
      end else if (run_q == limit_ext) begin
        run_d = run_q + 1'b1;
        acc_d = class_i;
      end else begin
        run_d = run_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= CLS_UNKNOWN;
      acc_q  <= CLS_UNKNOWN;
      run_q  <= '0;
    end else if (step_i) begin
      cand_q <= cand_d;
      acc_q  <= acc_d;
      run_q  <= run_d;
    end
  end

  always_comb begin
    raw_value_o   = '0;
    left_right_o  = 2'sd0;
    back_front_o  = 2'sd0;
    status_code_o = 3'd0;
    unique case (cfg_i.mode)
      MODE_RAW: raw_value_o = sample_i;
      MODE_AXIS: begin
        unique case (acc_d)
          CLS_BACK:  back_front_o = -2'sd1;
          CLS_RIGHT: left_right_o = 2'sd1;
          CLS_FRONT: back_front_o = 2'sd1;
          CLS_LEFT:  left_right_o = -2'sd1;
          default: ;
        endcase
      end
      MODE_STATUS: begin
        unique case (acc_d)
          CLS_BACK:  status_code_o = 3'd2;
          CLS_RIGHT: status_code_o = 3'd4;
          CLS_FRONT: status_code_o = 3'd1;
          CLS_LEFT:  status_code_o = 3'd3;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  a_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q <= RUN_MAX)
    else $error("debounce run count above its ceiling");

  a_acc_is_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(acc_q) |-> acc_q == cand_q)
    else $error("accepted class changed to a class that is not the candidate");

  a_hold_unclassified: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !classifying |=> $stable(cand_q) && $stable(acc_q) && $stable(run_q))
    else $error("debounce state moved outside a classifying mode");

  a_new_cand_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cand_q) |-> run_q == '0)
    else $error("new candidate without a cleared run count");

endmodule

`default_nettype wire

// ===== rtl/tilt_classifier_debounce.sv =====
// ----------------------------------------------------------------------------
// tilt_classifier_debounce
// Six-class tilt quantizer with debounce and raw, axis or status code output.
// ----------------------------------------------------------------------------
// An accepted sample beat moves from the input register to the result register.
// Throughput: one beat per cycle while the receiver is ready; the input and result
// registers are separated by one pass of compares, debounce update and output
// mapping. Reset clears the valid flags and the debounce state to the unknown
// class and loads every configuration register with its documented default.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_classifier_debounce import tcd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [SampleW-1:0] tilt_sample_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [SampleW-1:0] raw_value_o,
  output logic signed [1:0]       left_right_o,
  output logic signed [1:0]       back_front_o,
  output logic      [2:0]         status_code_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [AddrW-1:0]   paddr,
  input  wire logic [DataW-1:0]   pwdata,
  output logic      [DataW-1:0]   prdata,
  output logic                    pready
);

  tcd_cfg_t           cfg;
  tcd_class_e         cls;
  logic               in_vq;
  logic [SampleW-1:0] in_sample_q;
  logic               adv;
  logic               out_vq;
  logic [SampleW-1:0] raw_d, raw_q;
  logic signed [1:0]  lr_d, lr_q;
  logic signed [1:0]  bf_d, bf_q;
  logic [2:0]         sc_d, sc_q;

  tcd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign adv        = in_vq & (~out_vq | out_ready_i);
  assign in_ready_o = ~in_vq | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_ready_o) begin
      in_vq <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_sample_q <= tilt_sample_i;
    end
  end

  tcd_classify u_classify (
    .sample_i (in_sample_q),
    .thr_i    (cfg.thr),
    .class_o  (cls)
  );

  tcd_debounce u_debounce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (adv),
    .sample_i      (in_sample_q),
    .class_i       (cls),
    .cfg_i         (cfg),
    .raw_value_o   (raw_d),
    .left_right_o  (lr_d),
    .back_front_o  (bf_d),
    .status_code_o (sc_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (~out_vq | out_ready_i) begin
      out_vq <= in_vq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      raw_q <= raw_d;
      lr_q  <= lr_d;
      bf_q  <= bf_d;
      sc_q  <= sc_d;
    end
  end

  assign out_valid_o   = out_vq;
  assign raw_value_o   = raw_q;
  assign left_right_o  = lr_q;
  assign back_front_o  = bf_q;
  assign status_code_o = sc_q;

endmodule

`default_nettype wire

// ===== dv/tilt_classifier_debounce_tb.sv =====
// ----------------------------------------------------------------------------
// tilt_classifier_debounce_tb
// Self-checking testbench for the tilt classifier with debounce. A directed
// table covers reset behavior, class boundaries, every output mode, limit
// changes mid-run and unordered thresholds. Random segments with new register
// settings follow. Each beat is checked against a pinned value or a local model
// of classifier and debounce, under random sender/receiver stalls in most phases.
// ----------------------------------------------------------------------------

module tilt_classifier_debounce_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcd_pkg::*;

  typedef struct packed {
    logic [SampleW-1:0] raw_value;
    logic signed [1:0]  left_right;
    logic signed [1:0]  back_front;
    logic [2:0]         status_code;
  } tilt_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [RegIdxW-1:0] reg_idx;
    logic [SampleW-1:0] value;
    logic               pinned;
    tilt_result_t       golden;
  } stim_row_t;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic signed [1:0] AXIS_POS  = 2'sd1;
  localparam logic signed [1:0] AXIS_ZERO = 2'sd0;
  localparam logic signed [1:0] AXIS_NEG  = -2'sd1;

  localparam logic [2:0] STAT_NONE  = 3'd0;
  localparam logic [2:0] STAT_FRONT = 3'd1;
  localparam logic [2:0] STAT_BACK  = 3'd2;
  localparam logic [2:0] STAT_LEFT  = 3'd3;
  localparam logic [2:0] STAT_RIGHT = 3'd4;

  localparam tilt_result_t RES_ZERO      = '0;
  localparam tilt_result_t RES_LEFT_AXIS = '{8'd0, AXIS_NEG, AXIS_ZERO, STAT_NONE};
  localparam tilt_result_t RES_RAW_A5    = '{8'hA5, AXIS_ZERO, AXIS_ZERO, STAT_NONE};
  localparam tilt_result_t RES_RAW_5A    = '{8'h5A, AXIS_ZERO, AXIS_ZERO, STAT_NONE};

  localparam int NUM_ROWS       = 37;
  localparam int NUM_PHASES     = 3;
  localparam int SEGS_PER_PHASE = 9;
  localparam int SEG_ITEMS      = 70;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 5000;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [SampleW-1:0] tilt_sample_i = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic [SampleW-1:0] raw_value_o;
  logic signed [1:0]  left_right_o;
  logic signed [1:0]  back_front_o;
  logic [2:0]         status_code_o;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [AddrW-1:0]   paddr         = '0;
  logic [DataW-1:0]   pwdata        = '0;
  logic [DataW-1:0]   prdata;
  logic               pready;

  tilt_classifier_debounce DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .tilt_sample_i (tilt_sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .raw_value_o   (raw_value_o),
    .left_right_o  (left_right_o),
    .back_front_o  (back_front_o),
    .status_code_o (status_code_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Local copy of the configuration and debounce state.
  logic [1:0]         cfg_mode  = RST_OUTPUT_MODE;
  logic [LimitW-1:0]  cfg_limit = RST_DEBOUNCE_LIMIT;
  logic [SampleW-1:0] cfg_thr [NumThr] = '{RST_UNKNOWN_MAX, RST_BACK_MAX, RST_RIGHT_MAX,
                                           RST_LEVEL_MAX, RST_FRONT_MAX};
  tcd_class_e         cand_cls  = CLS_UNKNOWN;
  logic [RunW-1:0]    run_cnt   = '0;
  tcd_class_e         acc_cls   = CLS_UNKNOWN;

  tilt_result_t pending_results [$];
  logic         pin_active = 1'b0;
  tilt_result_t pin_result = '0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  mismatch_cnt  = 0;
  int unsigned  quiet_cycles  = 0;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_SAMPLE, '0, 8'd255, 1'b1, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'd255, 1'b1, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'd255, 1'b1, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'd255, 1'b1, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'd255, 1'b1, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'd255, 1'b1, RES_LEFT_AXIS},
    '{ROW_SAMPLE, '0, 8'd0,   1'b1, RES_LEFT_AXIS},
    '{ROW_SAMPLE, '0, 8'd48,  1'b0, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'd154, 1'b0, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'd205, 1'b0, RES_ZERO},
    '{ROW_WRITE,  REG_OUTPUT_MODE, 8'(MODE_RAW), 1'b0, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'hA5,  1'b1, RES_RAW_A5},
    '{ROW_SAMPLE, '0, 8'h5A,  1'b1, RES_RAW_5A},
    '{ROW_WRITE,  REG_OUTPUT_MODE, 8'(MODE_UNUSED), 1'b0, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'hFF,  1'b1, RES_ZERO},
    '{ROW_WRITE,  REG_OUTPUT_MODE, 8'(MODE_STATUS), 1'b0, RES_ZERO},
    '{ROW_WRITE,  REG_DEBOUNCE_LIMIT, 8'd0, 1'b0, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'd30,  1'b0, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'd30,  1'b0, RES_ZERO},
    '{ROW_WRITE,  REG_DEBOUNCE_LIMIT, 8'd3, 1'b0, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'd30,  1'b0, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'd30,  1'b0, RES_ZERO},
    '{ROW_WRITE,  REG_DEBOUNCE_LIMIT, 8'd1, 1'b0, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'd30,  1'b0, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'd200, 1'b0, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'd200, 1'b0, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'd200, 1'b0, RES_ZERO},
    '{ROW_WRITE,  REG_UNKNOWN_MAX, 8'd255, 1'b0, RES_ZERO},
    '{ROW_WRITE,  REG_BACK_MAX,    8'd0,   1'b0, RES_ZERO},
    '{ROW_WRITE,  REG_RIGHT_MAX,   8'd255, 1'b0, RES_ZERO},
    '{ROW_WRITE,  REG_LEVEL_MAX,   8'd0,   1'b0, RES_ZERO},
    '{ROW_WRITE,  REG_FRONT_MAX,   8'd0,   1'b0, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'd128, 1'b0, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'd255, 1'b0, RES_ZERO},
    '{ROW_WRITE,  REG_UNKNOWN_MAX, 8'd0, 1'b0, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'd0,   1'b0, RES_ZERO},
    '{ROW_SAMPLE, '0, 8'd1,   1'b0, RES_ZERO}
  };

  function automatic tcd_class_e tilt_class_of(input logic [SampleW-1:0] s);
    tcd_class_e cls;
    cls = CLS_LEFT;
    for (int k = NumThr - 1; k >= 0; k--) begin
      if (s <= cfg_thr[k]) cls = tcd_class_e'(3'(k));
    end
    return cls;
  endfunction

  function automatic tilt_result_t predict_tilt_result(input logic [SampleW-1:0] s);
    tilt_result_t r;
    tcd_class_e   cls;
    r = '0;
    if (cfg_mode == MODE_RAW) begin
      r.raw_value = s;
    end else if (cfg_mode == MODE_AXIS || cfg_mode == MODE_STATUS) begin
      cls = tilt_class_of(s);
      if (cls != cand_cls) begin
        cand_cls = cls;
        run_cnt  = '0;
      end else if (run_cnt < {1'b0, cfg_limit}) begin
        run_cnt = run_cnt + 1'b1;
      end else if (run_cnt == {1'b0, cfg_limit}) begin
        run_cnt = run_cnt + 1'b1;
        acc_cls = cls;
      end
      if (cfg_mode == MODE_AXIS) begin
        case (acc_cls)
          CLS_BACK:  r.back_front = AXIS_NEG;
          CLS_RIGHT: r.left_right = AXIS_POS;
          CLS_FRONT: r.back_front = AXIS_POS;
          CLS_LEFT:  r.left_right = AXIS_NEG;
          default:   r.left_right = AXIS_ZERO;
        endcase
      end else begin
        case (acc_cls)
          CLS_BACK:  r.status_code = STAT_BACK;
          CLS_RIGHT: r.status_code = STAT_RIGHT;
          CLS_FRONT: r.status_code = STAT_FRONT;
          CLS_LEFT:  r.status_code = STAT_LEFT;
          default:   r.status_code = STAT_NONE;
        endcase
      end
    end
    return r;
  endfunction

  function automatic string format_result(input tilt_result_t r);
    return $sformatf("raw=%0d lr=%0d bf=%0d code=%0d",
                     r.raw_value, r.left_right, r.back_front, r.status_code);
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t: MISMATCH %s", $realtime, msg);
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : beat_monitor
    tilt_result_t got;
    tilt_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{raw_value_o, left_right_o, back_front_o, status_code_o};
        if (pending_results.size() == 0) begin
          note_mismatch({"result beat with nothing expected: ", format_result(got)});
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            note_mismatch({"expected ", format_result(want), ", got ", format_result(got)});
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        want = predict_tilt_result(tilt_sample_i);
        if (pin_active) want = pin_result;
        pending_results.push_back(want);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tilt_classifier_debounce regression: fail");
      $finish;
    end
  end

  task automatic send_tilt(input logic [SampleW-1:0] s, input logic pin,
                           input tilt_result_t gold);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    tilt_sample_i <= s;
    pin_active    <= pin;
    pin_result    <= gold;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic apb_write_reg(input logic [RegIdxW-1:0] idx, input logic [SampleW-1:0] val);
    logic [SampleW-1:0] readback;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_OUTPUT_MODE:    cfg_mode  = val[1:0];
      REG_DEBOUNCE_LIMIT: cfg_limit = val[LimitW-1:0];
      default:            cfg_thr[idx - REG_UNKNOWN_MAX] = val;
    endcase
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_OUTPUT_MODE:    readback = {6'd0, cfg_mode};
      REG_DEBOUNCE_LIMIT: readback = {4'd0, cfg_limit};
      default:            readback = cfg_thr[idx - REG_UNKNOWN_MAX];
    endcase
    if (prdata !== DataW'(readback)) begin
      note_mismatch($sformatf("register %0d reads %0h, expected %0h", idx, prdata, readback));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic shuffle_config(input bit write_all);
    logic [SampleW-1:0] thr_q [$];
    logic [1:0]         mode;
    logic [LimitW-1:0]  lim;
    int unsigned        style;
    if (write_all || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 9))
        0:          mode = MODE_RAW;
        1:          mode = MODE_UNUSED;
        2, 3, 4, 5: mode = MODE_AXIS;
        default:    mode = MODE_STATUS;
      endcase
      apb_write_reg(REG_OUTPUT_MODE, {6'($urandom), mode});
    end
    if (write_all || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0:       lim = '0;
        1:       lim = '1;
        default: lim = LimitW'($urandom);
      endcase
      apb_write_reg(REG_DEBOUNCE_LIMIT, {4'($urandom), lim});
    end
    if (write_all || $urandom_range(0, 1)) begin
      style = $urandom_range(0, 9);
      if (style == 0) begin
        thr_q = '{RST_UNKNOWN_MAX, RST_BACK_MAX, RST_RIGHT_MAX, RST_LEVEL_MAX, RST_FRONT_MAX};
      end else begin
        for (int k = 0; k < NumThr; k++) begin
          if (style >= 8) thr_q.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
          else thr_q.push_back(8'($urandom));
        end
        if (style <= 5) thr_q.sort();
      end
      for (int k = 0; k < NumThr; k++) begin
        apb_write_reg(REG_UNKNOWN_MAX + RegIdxW'(k), thr_q[k]);
      end
    end
  endtask

  initial begin
    int                 left;
    int                 burst;
    logic [SampleW-1:0] base;
    logic [SampleW-1:0] s;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 32;
    recv_idle_pct = 61;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        wait_idle();
        apb_write_reg(directed_rows[r].reg_idx, directed_rows[r].value);
      end else begin
        send_tilt(directed_rows[r].value, directed_rows[r].pinned, directed_rows[r].golden);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 32; recv_idle_pct = 61; end
        1:       begin send_idle_pct = 61; recv_idle_pct = 32; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int seg = 0; seg < SEGS_PER_PHASE; seg++) begin
        wait_idle();
        shuffle_config(seg == 0);
        left = SEG_ITEMS;
        while (left > 0) begin
          burst = $urandom_range(1, 20);
          if ($urandom_range(0, 1)) base = 8'($urandom);
          else base = cfg_thr[$urandom_range(0, NumThr - 1)] + 8'($urandom_range(0, 2)) - 8'd1;
          while (burst > 0 && left > 0) begin
            s = ($urandom_range(99) < 12) ? 8'($urandom) : base;
            send_tilt(s, 1'b0, RES_ZERO);
            burst--;
            left--;
          end
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tilt_classifier_debounce regression: pass");
    end else begin
      $display("tilt_classifier_debounce regression: fail");
    end
    $finish;
  end

endmodule
